>>> design/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants for the closest point on triangle block
// Beat types of both channels, the region codes and the datapath widths.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int unsigned CW      = 32;
  localparam int unsigned FRAC    = 30;
  localparam int unsigned NW      = 140;
  localparam int unsigned DIV_LAT = FRAC + 2;

  typedef enum logic [2:0] {
    REG_A   = 3'd0,
    REG_B   = 3'd1,
    REG_C   = 3'd2,
    REG_AB  = 3'd3,
    REG_AC  = 3'd4,
    REG_BC  = 3'd5,
    REG_INT = 3'd6
  } region_e;

  typedef struct packed {
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_z;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic signed [CW-1:0] near_z;
    region_e              region;
    logic                 degenerate;
  } result_t;

endpackage

>>> design/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div: pipelined fraction divider
// Gives num/den as unsigned Q1.30 in [0, 1], saturated and rounded half up,
// one restoring step per stage, a new operand pair in every cycle.
// ----------------------------------------------------------------------------
module cpt_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [cpt_pkg::NW-1:0]  num_i,
  input  logic signed [cpt_pkg::NW-1:0]  den_i,
  output logic                           valid_o,
  output logic [cpt_pkg::FRAC:0]         q_o
);

  localparam int unsigned NW   = cpt_pkg::NW;
  localparam int unsigned FRAC = cpt_pkg::FRAC;
  localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};

  logic [NW-1:0]   r_q    [FRAC+1];
  logic [NW-1:0]   d_q    [FRAC+1];
  logic [FRAC-1:0] q_q    [FRAC+1];
  logic            zero_q [FRAC+1];
  logic            one_q  [FRAC+1];
  logic            v_q    [FRAC+1];
  logic [NW-1:0]   r_d    [FRAC];
  logic [FRAC-1:0] q_d    [FRAC];
  logic            zero_d;
  logic            one_d;
  logic [NW-1:0]   rf;
  logic            gef;
  logic [FRAC:0]   q_fin;
  logic [FRAC:0]   q_out_q;
  logic            v_out_q;

  assign zero_d = (den_i <= 0) || (num_i <= 0);
  assign one_d  = !zero_d && (num_i >= den_i);

  always_comb begin
    for (int k = 0; k < FRAC; k++) begin
      if ({r_q[k][NW-2:0], 1'b0} >= d_q[k]) begin
        r_d[k] = {r_q[k][NW-2:0], 1'b0} - d_q[k];
        q_d[k] = {q_q[k][FRAC-2:0], 1'b1};
      end else begin
        r_d[k] = {r_q[k][NW-2:0], 1'b0};
        q_d[k] = {q_q[k][FRAC-2:0], 1'b0};
      end
    end
  end

  assign rf  = {r_q[FRAC][NW-2:0], 1'b0};
  assign gef = rf >= d_q[FRAC];

  always_comb begin
    if (zero_q[FRAC]) begin
      q_fin = '0;
    end else if (one_q[FRAC]) begin
      q_fin = ONE;
    end else begin
      q_fin = {1'b0, q_q[FRAC]} + (FRAC+1)'(gef);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= FRAC; k++) v_q[k] <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= FRAC; k++) v_q[k] <= v_q[k-1];
      v_out_q <= v_q[FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]    <= num_i;
    d_q[0]    <= den_i;
    q_q[0]    <= '0;
    zero_q[0] <= zero_d;
    one_q[0]  <= one_d;
    for (int k = 1; k <= FRAC; k++) begin
      r_q[k]    <= r_d[k-1];
      d_q[k]    <= d_q[k-1];
      q_q[k]    <= q_d[k-1];
      zero_q[k] <= zero_q[k-1];
      one_q[k]  <= one_q[k-1];
    end
    q_out_q <= q_fin;
  end

  assign valid_o = v_out_q;
  assign q_o     = q_out_q;

  a_q_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (q_o <= ONE))
    else $error("divider quotient above one");

  a_q_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##(cpt_pkg::DIV_LAT) valid_o)
    else $error("divider strobe missing after an operand pair");

  a_q_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$isunknown(q_o))
    else $error("divider quotient unknown");

endmodule

>>> design/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle: nearest point of a 3-D triangle to a query point
// Voronoi region test on edge dot products, exact wide products, pipelined.
// ----------------------------------------------------------------------------
// Usage. A beat is offered on item_i with start high; it is taken at the
// rising edge where start is high and busy is low. busy stays low, so a new
// beat can be taken in every cycle. All coordinates are signed Q16.16.
// Each result leaves on result_o with valid_o high for exactly one cycle,
// in order of arrival. The receiver cannot stall the block, and nothing
// inside ever waits. Throughput is one beat per cycle; a beat passes seven
// stages of products and classification, the 32-stage fraction divider (one
// restoring step per quotient bit) and two stages of scaling, rounding and
// saturation. Reset clears all valid bits, so no result leaves until a beat
// is taken after reset.
// ----------------------------------------------------------------------------
module closest_point_on_triangle (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cpt_pkg::item_t    item_i,
  output logic              valid_o,
  output cpt_pkg::result_t  result_o
);

  localparam int unsigned FRAC = cpt_pkg::FRAC;
  localparam int unsigned NW   = cpt_pkg::NW;
  localparam int unsigned NPRE = 7;
  localparam int unsigned LAT  = NPRE + cpt_pkg::DIV_LAT + 2;
  localparam int unsigned PX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int unsigned PY [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct packed {
    logic [2:0][31:0]  base;
    logic [2:0][32:0]  v1;
    logic [2:0][32:0]  v2;
    cpt_pkg::region_e  region;
    logic              degen;
  } carry_t;

  typedef struct packed {
    logic [2:0][62:0]  p1;
    logic [2:0][62:0]  p2;
    logic [2:0]        n1;
    logic [2:0]        n2;
    logic [2:0][31:0]  base;
    cpt_pkg::region_e  region;
    logic              degen;
  } mul_t;

  logic              vld_q [NPRE];
  cpt_pkg::item_t    it_q  [NPRE];

  logic signed [31:0]  ain [3];
  logic signed [31:0]  bin [3];
  logic signed [31:0]  cin [3];
  logic signed [31:0]  pin [3];
  logic signed [32:0]  vec_d [5][3];
  logic signed [32:0]  vec_q [5][3];
  logic signed [65:0]  pr_d  [6][3];
  logic signed [65:0]  pr_q  [6][3];
  logic signed [67:0]  dot_d [6];
  logic signed [67:0]  dot3_q [6];
  logic signed [67:0]  dot4_q [6];
  logic signed [67:0]  dot5_q [6];
  logic signed [67:0]  dot6_q [6];
  logic signed [67:0]  dot7_q [6];

  logic signed [33:0]  xh [6];
  logic signed [33:0]  yh [6];
  logic signed [34:0]  xl [6];
  logic signed [34:0]  yl [6];
  logic signed [67:0]  hh_d [6];
  logic signed [68:0]  hl_d [6];
  logic signed [68:0]  lh_d [6];
  logic [67:0]         ll_d [6];
  logic signed [67:0]  hh_q [6];
  logic signed [68:0]  hl_q [6];
  logic signed [68:0]  lh_q [6];
  logic [67:0]         ll_q [6];
  logic signed [135:0] cross_d [6];
  logic signed [135:0] cross_q [6];

  logic signed [136:0] va_q, vb_q, vc_q;
  logic signed [68:0]  e1_q, e2_q;

  cpt_pkg::region_e    reg_d, reg7_q;
  logic signed [138:0] den7_q;
  logic signed [136:0] vb7_q, vc7_q;
  logic signed [68:0]  e17_q, dab7_q, dac7_q;
  logic signed [69:0]  dbc7_q;

  logic signed [31:0]  a7 [3];
  logic signed [31:0]  b7 [3];
  logic signed [31:0]  c7 [3];
  logic signed [NW-1:0] num_a, den_a, num_b, den_b;
  carry_t              carry_d;
  carry_t              carry_q [cpt_pkg::DIV_LAT];

  logic                div_va, div_vb;
  logic [FRAC:0]       t_a, t_b;

  mul_t                mul_d, mul_q;
  logic                mv_q;
  cpt_pkg::result_t    res_d, res_q;
  logic                rv_q;

  assign busy = 1'b0;

  // Stage 1: edge and query vectors.
  always_comb begin
    pin[0] = item_i.query_x; pin[1] = item_i.query_y; pin[2] = item_i.query_z;
    ain[0] = item_i.a_x;     ain[1] = item_i.a_y;     ain[2] = item_i.a_z;
    bin[0] = item_i.b_x;     bin[1] = item_i.b_y;     bin[2] = item_i.b_z;
    cin[0] = item_i.c_x;     cin[1] = item_i.c_y;     cin[2] = item_i.c_z;
    for (int i = 0; i < 3; i++) begin
      vec_d[0][i] = 33'(bin[i]) - 33'(ain[i]);
      vec_d[1][i] = 33'(cin[i]) - 33'(ain[i]);
      vec_d[2][i] = 33'(pin[i]) - 33'(ain[i]);
      vec_d[3][i] = 33'(pin[i]) - 33'(bin[i]);
      vec_d[4][i] = 33'(pin[i]) - 33'(cin[i]);
    end
  end

  // Stages 2 and 3: dot products d1 to d6.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int u = 0; u < 2; u++) begin
        for (int i = 0; i < 3; i++) begin
          pr_d[2*j+u][i] = vec_q[u][i] * vec_q[2+j][i];
        end
      end
    end
    for (int k = 0; k < 6; k++) begin
      dot_d[k] = 68'(pr_q[k][0]) + 68'(pr_q[k][1]) + 68'(pr_q[k][2]);
    end
  end

  // Stages 4 and 5: cross terms from four partial products each.
  always_comb begin
    for (int m = 0; m < 6; m++) begin
      xh[m]   = dot3_q[PX[m]][67:34];
      yh[m]   = dot3_q[PY[m]][67:34];
      xl[m]   = {1'b0, dot3_q[PX[m]][33:0]};
      yl[m]   = {1'b0, dot3_q[PY[m]][33:0]};
      hh_d[m] = xh[m] * yh[m];
      hl_d[m] = xh[m] * yl[m];
      lh_d[m] = xl[m] * yh[m];
      ll_d[m] = dot3_q[PX[m]][33:0] * dot3_q[PY[m]][33:0];
      cross_d[m] = {hh_q[m], 68'd0} + (136'(hl_q[m]) << 34) + (136'(lh_q[m]) << 34)
                 + 136'(ll_q[m]);
    end
  end

  // Stage 7: region classification.
  always_comb begin
    if (dot6_q[0] <= 0 && dot6_q[1] <= 0) begin
      reg_d = cpt_pkg::REG_A;
    end else if (dot6_q[2] >= 0 && dot6_q[3] <= dot6_q[2]) begin
      reg_d = cpt_pkg::REG_B;
    end else if (vc_q <= 0 && dot6_q[0] >= 0 && dot6_q[2] <= 0) begin
      reg_d = cpt_pkg::REG_AB;
    end else if (dot6_q[5] >= 0 && dot6_q[4] <= dot6_q[5]) begin
      reg_d = cpt_pkg::REG_C;
    end else if (vb_q <= 0 && dot6_q[1] >= 0 && dot6_q[5] <= 0) begin
      reg_d = cpt_pkg::REG_AC;
    end else if (va_q <= 0 && e1_q >= 0 && e2_q >= 0) begin
      reg_d = cpt_pkg::REG_BC;
    end else begin
      reg_d = cpt_pkg::REG_INT;
    end
  end

  // Divider operands and the values that travel beside the divider.
  always_comb begin
    a7[0] = it_q[NPRE-1].a_x; a7[1] = it_q[NPRE-1].a_y; a7[2] = it_q[NPRE-1].a_z;
    b7[0] = it_q[NPRE-1].b_x; b7[1] = it_q[NPRE-1].b_y; b7[2] = it_q[NPRE-1].b_z;
    c7[0] = it_q[NPRE-1].c_x; c7[1] = it_q[NPRE-1].c_y; c7[2] = it_q[NPRE-1].c_z;
    num_a = '0;
    den_a = '0;
    num_b = '0;
    den_b = '0;
    carry_d.v1     = '0;
    carry_d.v2     = '0;
    carry_d.region = reg7_q;
    carry_d.degen  = 1'b0;
    for (int i = 0; i < 3; i++) carry_d.base[i] = a7[i];
    case (reg7_q)
      cpt_pkg::REG_B: begin
        for (int i = 0; i < 3; i++) carry_d.base[i] = b7[i];
      end
      cpt_pkg::REG_C: begin
        for (int i = 0; i < 3; i++) carry_d.base[i] = c7[i];
      end
      cpt_pkg::REG_AB: begin
        for (int i = 0; i < 3; i++) carry_d.v1[i] = 33'(b7[i]) - 33'(a7[i]);
        num_a = NW'(dot7_q[0]);
        den_a = NW'(dab7_q);
      end
      cpt_pkg::REG_AC: begin
        for (int i = 0; i < 3; i++) carry_d.v1[i] = 33'(c7[i]) - 33'(a7[i]);
        num_a = NW'(dot7_q[1]);
        den_a = NW'(dac7_q);
      end
      cpt_pkg::REG_BC: begin
        for (int i = 0; i < 3; i++) begin
          carry_d.base[i] = b7[i];
          carry_d.v1[i]   = 33'(c7[i]) - 33'(b7[i]);
        end
        num_a = NW'(e17_q);
        den_a = NW'(dbc7_q);
      end
      cpt_pkg::REG_INT: begin
        for (int i = 0; i < 3; i++) begin
          carry_d.v1[i] = 33'(b7[i]) - 33'(a7[i]);
          carry_d.v2[i] = 33'(c7[i]) - 33'(a7[i]);
        end
        num_a = NW'(vb7_q);
        den_a = NW'(den7_q);
        num_b = NW'(vc7_q);
        den_b = NW'(den7_q);
        carry_d.degen = den7_q <= 0;
      end
      default: begin
        num_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NPRE; k++) vld_q[k] <= 1'b0;
      mv_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      vld_q[0] <= start && !busy;
      for (int k = 1; k < NPRE; k++) vld_q[k] <= vld_q[k-1];
      mv_q <= div_va;
      rv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q[0] <= item_i;
    for (int k = 1; k < NPRE; k++) it_q[k] <= it_q[k-1];
    vec_q  <= vec_d;
    pr_q   <= pr_d;
    dot3_q <= dot_d;
    dot4_q <= dot3_q;
    dot5_q <= dot4_q;
    dot6_q <= dot5_q;
    dot7_q <= dot6_q;
    hh_q   <= hh_d;
    hl_q   <= hl_d;
    lh_q   <= lh_d;
    ll_q   <= ll_d;
    cross_q <= cross_d;
    vc_q   <= 137'(cross_q[0]) - 137'(cross_q[1]);
    vb_q   <= 137'(cross_q[2]) - 137'(cross_q[3]);
    va_q   <= 137'(cross_q[4]) - 137'(cross_q[5]);
    e1_q   <= 69'(dot5_q[3]) - 69'(dot5_q[2]);
    e2_q   <= 69'(dot5_q[4]) - 69'(dot5_q[5]);
    reg7_q <= reg_d;
    den7_q <= 139'(va_q) + 139'(vb_q) + 139'(vc_q);
    vb7_q  <= vb_q;
    vc7_q  <= vc_q;
    e17_q  <= e1_q;
    dab7_q <= 69'(dot6_q[0]) - 69'(dot6_q[2]);
    dac7_q <= 69'(dot6_q[1]) - 69'(dot6_q[5]);
    dbc7_q <= 70'(e1_q) + 70'(e2_q);
    carry_q[0] <= carry_d;
    for (int k = 1; k < cpt_pkg::DIV_LAT; k++) carry_q[k] <= carry_q[k-1];
    mul_q  <= mul_d;
    res_q  <= res_d;
  end

  cpt_div u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[NPRE-1]),
    .num_i   (num_a),
    .den_i   (den_a),
    .valid_o (div_va),
    .q_o     (t_a)
  );

  cpt_div u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[NPRE-1]),
    .num_i   (num_b),
    .den_i   (den_b),
    .valid_o (div_vb),
    .q_o     (t_b)
  );

  // Scaling of the edge vectors by the parameters.
  always_comb begin
    logic [32:0] m1;
    logic [32:0] m2;
    carry_t      cq;
    cq = carry_q[cpt_pkg::DIV_LAT-1];
    mul_d.base   = cq.base;
    mul_d.region = cq.region;
    mul_d.degen  = cq.degen;
    for (int i = 0; i < 3; i++) begin
      mul_d.n1[i] = cq.v1[i][32];
      mul_d.n2[i] = cq.v2[i][32];
      m1 = cq.v1[i][32] ? (33'd0 - cq.v1[i]) : cq.v1[i];
      m2 = cq.v2[i][32] ? (33'd0 - cq.v2[i]) : cq.v2[i];
      mul_d.p1[i] = m1[31:0] * t_a;
      mul_d.p2[i] = m2[31:0] * t_b;
    end
  end

  // Rounding, sum with the base vertex and saturation.
  always_comb begin
    logic [32:0]        r1;
    logic [32:0]        r2;
    logic signed [33:0] s1;
    logic signed [33:0] s2;
    logic signed [35:0] sum;
    logic signed [31:0] near [3];
    for (int i = 0; i < 3; i++) begin
      r1 = 33'((mul_q.p1[i] + (63'(1) << (FRAC-1))) >> FRAC);
      r2 = 33'((mul_q.p2[i] + (63'(1) << (FRAC-1))) >> FRAC);
      s1 = mul_q.n1[i] ? -$signed({1'b0, r1}) : $signed({1'b0, r1});
      s2 = mul_q.n2[i] ? -$signed({1'b0, r2}) : $signed({1'b0, r2});
      sum = 36'($signed(mul_q.base[i])) + 36'(s1) + 36'(s2);
      if (sum > 36'sd2147483647) begin
        near[i] = 32'sh7fffffff;
      end else if (sum < -36'sd2147483648) begin
        near[i] = 32'sh80000000;
      end else begin
        near[i] = sum[31:0];
      end
    end
    res_d.near_x     = near[0];
    res_d.near_y     = near[1];
    res_d.near_z     = near[2];
    res_d.region     = mul_q.region;
    res_d.degenerate = mul_q.degen;
  end

  assign valid_o  = rv_q;
  assign result_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(LAT) valid_o)
    else $error("result strobe missing after an accepted beat");

  a_degen_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!result_o.degenerate || result_o.region == cpt_pkg::REG_INT))
    else $error("degenerate flag outside the interior region");

  a_vertex_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && (mul_q.region == cpt_pkg::REG_A || mul_q.region == cpt_pkg::REG_B
              || mul_q.region == cpt_pkg::REG_C))
    |-> (mul_q.p1 == '0 && mul_q.p2 == '0))
    else $error("vertex region with a nonzero edge term");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_va == div_vb)
    else $error("divider pipelines out of step");

endmodule
